// File: rtl/core/tmcg_pkg.sv
// Shared types, constants and the color palette of the text-mode character generator.
// No dependencies; every other file in rtl/core except tmcg_ram imports this package.
`timescale 1ns / 1ps

package tmcg_pkg;

  // Default geometry of the text screen and the font.
  localparam int TEXT_COLUMNS = 40;
  localparam int TEXT_ROWS    = 15;
  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_COUNT  = 95;

  // Depth of the result queue in front of the output port.
  localparam int OUT_FIFO_DEPTH = 4;

  // Printable code range: codes from FIRST_CODE up to but not including END_CODE.
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] END_CODE   = 8'h7F;

  typedef enum logic [1:0] {
    MODE_WRITE_CHAR = 2'd0,
    MODE_WRITE_ATTR = 2'd1,
    MODE_WRITE_FONT = 2'd2,
    MODE_RENDER     = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [9:0]  cell_index;
    logic [10:0] glyph_row_address;
    logic [7:0]  data_byte;
    logic [7:0]  scanline;
    logic [5:0]  column;
  } in_req_t;

  typedef struct packed {
    logic [15:0] pixel_0;
    logic [15:0] pixel_1;
    logic [15:0] pixel_2;
    logic [15:0] pixel_3;
    logic [15:0] pixel_4;
    logic [15:0] pixel_5;
    logic [15:0] pixel_6;
    logic [15:0] pixel_7;
    logic        end_of_line;
  } out_res_t;

  // Colors are packed with red in bits 0-4, green in bits 6-10 and blue in bits 11-15.
  function automatic logic [15:0] palette_color(input logic [3:0] idx);
    logic [15:0] color;
    case (idx)
      4'd0:    color = 16'h0000;
      4'd1:    color = 16'h7800;
      4'd2:    color = 16'h03C0;
      4'd3:    color = 16'h7BC0;
      4'd4:    color = 16'h000F;
      4'd5:    color = 16'h780F;
      4'd6:    color = 16'h03CF;
      4'd7:    color = 16'h7BCF;
      4'd8:    color = 16'h39C7;
      4'd9:    color = 16'hF800;
      4'd10:   color = 16'h07C0;
      4'd11:   color = 16'hFFC0;
      4'd12:   color = 16'h001F;
      4'd13:   color = 16'hF81F;
      4'd14:   color = 16'h07DF;
      4'd15:   color = 16'hFFDF;
      default: color = 16'h0000;
    endcase
    return color;
  endfunction

endpackage

// File: rtl/core/text_mode_character_generator.sv
// Top level of the text-mode character generator: render pipeline plus result queue.
// Depends on tmcg_pkg, tmcg_pipe, tmcg_out_fifo and, through the pipeline, tmcg_ram.
//
//   Port group   Direction  Handshake              Payload
//   request      in         in_valid_i/in_stall_o  in_req_i  (tmcg_pkg::in_req_t)
//   result       out        out_valid_o/out_stall_i out_res_o (tmcg_pkg::out_res_t)
//
// One request is taken every clock while in_stall_o is low. A render request passes
// the cell stores, then the glyph store, then the palette, each one stage, before the result queue.
// Write requests give no result and update their store in the stage that reads it.
// Reset clears only control state; the stores hold garbage until written.
// The input stalls only when the results in flight would overfill the result queue.
`timescale 1ns / 1ps

module text_mode_character_generator #(
  parameter int TextColumns = tmcg_pkg::TEXT_COLUMNS,
  parameter int TextRows    = tmcg_pkg::TEXT_ROWS,
  parameter int GlyphHeight = tmcg_pkg::GLYPH_HEIGHT,
  parameter int GlyphCount  = tmcg_pkg::GLYPH_COUNT,
  parameter int FifoDepth   = tmcg_pkg::OUT_FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tmcg_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tmcg_pkg::out_res_t out_res_o
);
  import tmcg_pkg::*;

  localparam int CntW = $clog2(FifoDepth + 1);

  logic            in_accept;
  logic            res_valid;
  out_res_t        res;
  logic [1:0]      inflight;
  logic            pop;
  logic [CntW-1:0] fifo_count;
  logic [CntW+1:0] used;

  assign in_accept = in_valid_i && !in_stall_o;
  assign pop       = out_valid_o && !out_stall_i;

  // Every render request in the pipeline holds a reserved queue slot.
  assign used       = (CntW + 2)'(inflight) + (CntW + 2)'(fifo_count) - (CntW + 2)'(pop);
  assign in_stall_o = int'(used) >= FifoDepth;

  tmcg_pipe #(
    .TextColumns (TextColumns),
    .TextRows    (TextRows),
    .GlyphHeight (GlyphHeight),
    .GlyphCount  (GlyphCount)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_accept),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .inflight_o  (inflight)
  );

  tmcg_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (out_res_o),
    .count_o     (fifo_count)
  );

endmodule

// File: rtl/core/tmcg_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// A read and a write of the same entry in one cycle return the old contents.
`timescale 1ns / 1ps

module tmcg_ram #(
  parameter int Width = 8,
  parameter int Depth = 600,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tmcg_pipe.sv
// Three-stage store pipeline: cell stores (character and attribute), glyph store, palette.
// Depends on tmcg_pkg and tmcg_ram. Every store is written in the stage that reads it.
`timescale 1ns / 1ps

module tmcg_pipe #(
  parameter int TextColumns = tmcg_pkg::TEXT_COLUMNS,
  parameter int TextRows    = tmcg_pkg::TEXT_ROWS,
  parameter int GlyphHeight = tmcg_pkg::GLYPH_HEIGHT,
  parameter int GlyphCount  = tmcg_pkg::GLYPH_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  tmcg_pkg::in_req_t  req_i,
  output logic               res_valid_o,
  output tmcg_pkg::out_res_t res_o,
  output logic [1:0]         inflight_o
);
  import tmcg_pkg::*;

  localparam int CellCount = TextColumns * TextRows;
  localparam int CellAw    = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int GlyphRows = GlyphCount * GlyphHeight;
  localparam int GlyphAw   = $clog2(GlyphRows);
  localparam int GlyphRowW = $clog2(GlyphHeight);
  localparam int TextRowW  = $clog2(255 / GlyphHeight + 1);
  // scanline / GlyphHeight as a multiply by a rounded-up reciprocal; exact for 8-bit lines.
  localparam int RecipShift = 16;
  localparam int Recip      = ((1 << RecipShift) + GlyphHeight - 1) / GlyphHeight;

  // Stage 0: split the scanline into text row (glyph row follows in stage 1).
  logic [23:0] row_prod;
  assign row_prod = 24'(req_i.scanline) * 24'(Recip);

  // Stage 1 registers.
  logic                s1_valid_q;
  in_req_t             s1_req_q;
  logic [TextRowW-1:0] s1_text_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q      <= req_i;
    s1_text_row_q <= row_prod[RecipShift +: TextRowW];
  end

  // Stage 1: cell address, visibility and the cell store accesses.
  logic                 s1_render;
  logic                 s1_row_ok;
  logic                 s1_col_ok;
  logic                 s1_last;
  logic [13:0]          s1_cell_sum;
  logic [7:0]           s1_row_base;
  logic [GlyphRowW-1:0] s1_glyph_row;
  logic                 s1_cell_wr_ok;
  logic                 char_we;
  logic                 attr_we;
  logic                 cell_re;
  logic [7:0]           char_rdata;
  logic [7:0]           attr_rdata;

  assign s1_render     = s1_valid_q && (s1_req_q.mode == MODE_RENDER);
  assign s1_row_ok     = int'(s1_text_row_q) < TextRows;
  assign s1_col_ok     = int'(s1_req_q.column) < TextColumns;
  assign s1_last       = int'(s1_req_q.column) == (TextColumns - 1);
  assign s1_cell_sum   = 14'(int'(s1_text_row_q) * TextColumns) + 14'(s1_req_q.column);
  assign s1_row_base   = 8'(int'(s1_text_row_q) * GlyphHeight);
  assign s1_glyph_row  = GlyphRowW'(s1_req_q.scanline - s1_row_base);
  assign s1_cell_wr_ok = int'(s1_req_q.cell_index) < CellCount;
  assign char_we       = s1_valid_q && (s1_req_q.mode == MODE_WRITE_CHAR) && s1_cell_wr_ok;
  assign attr_we       = s1_valid_q && (s1_req_q.mode == MODE_WRITE_ATTR) && s1_cell_wr_ok;
  assign cell_re       = s1_render && s1_row_ok && s1_col_ok;

  tmcg_ram #(
    .Width (8),
    .Depth (CellCount)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (CellAw'(s1_req_q.cell_index)),
    .wdata_i (s1_req_q.data_byte),
    .re_i    (cell_re),
    .raddr_i (CellAw'(s1_cell_sum)),
    .rdata_o (char_rdata)
  );

  tmcg_ram #(
    .Width (8),
    .Depth (CellCount)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (CellAw'(s1_req_q.cell_index)),
    .wdata_i (s1_req_q.data_byte),
    .re_i    (cell_re),
    .raddr_i (CellAw'(s1_cell_sum)),
    .rdata_o (attr_rdata)
  );

  // Stage 2 registers.
  logic                 s2_render_q;
  logic                 s2_font_wr_q;
  logic [10:0]          s2_gaddr_q;
  logic [7:0]           s2_data_q;
  logic [GlyphRowW-1:0] s2_glyph_row_q;
  logic                 s2_visible_q;
  logic                 s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_render_q  <= 1'b0;
      s2_font_wr_q <= 1'b0;
    end else begin
      s2_render_q  <= s1_render;
      s2_font_wr_q <= s1_valid_q && (s1_req_q.mode == MODE_WRITE_FONT);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_gaddr_q     <= s1_req_q.glyph_row_address;
    s2_data_q      <= s1_req_q.data_byte;
    s2_glyph_row_q <= s1_glyph_row;
    s2_visible_q   <= s1_row_ok && s1_col_ok;
    s2_last_q      <= s1_last;
  end

  // Stage 2: glyph lookup from the character code.
  logic [7:0]  s2_glyph;
  logic        s2_glyph_ok;
  logic [12:0] s2_glyph_addr;
  logic        glyph_we;
  logic        glyph_re;
  logic [7:0]  glyph_rdata;

  assign s2_glyph      = char_rdata - FIRST_CODE;
  assign s2_glyph_ok   = (char_rdata >= FIRST_CODE) && (char_rdata < END_CODE) &&
                         (int'(s2_glyph) < GlyphCount);
  assign s2_glyph_addr = 13'(int'(s2_glyph) * GlyphHeight) + 13'(s2_glyph_row_q);
  assign glyph_we      = s2_font_wr_q && (int'(s2_gaddr_q) < GlyphRows);
  assign glyph_re      = s2_render_q && s2_visible_q && s2_glyph_ok;

  tmcg_ram #(
    .Width (8),
    .Depth (GlyphRows)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (GlyphAw'(s2_gaddr_q)),
    .wdata_i (s2_data_q),
    .re_i    (glyph_re),
    .raddr_i (GlyphAw'(s2_glyph_addr)),
    .rdata_o (glyph_rdata)
  );

  // Stage 3 registers.
  logic       s3_valid_q;
  logic [7:0] s3_attr_q;
  logic       s3_glyph_ok_q;
  logic       s3_visible_q;
  logic       s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_render_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_attr_q     <= attr_rdata;
    s3_glyph_ok_q <= s2_glyph_ok;
    s3_visible_q  <= s2_visible_q;
    s3_last_q     <= s2_last_q;
  end

  // Stage 3: expand the glyph row through the palette.
  logic [7:0]  s3_bits;
  logic [15:0] s3_fg;
  logic [15:0] s3_bg;
  logic [15:0] pix [8];

  assign s3_bits = s3_glyph_ok_q ? glyph_rdata : 8'h00;
  assign s3_fg   = palette_color(s3_attr_q[3:0]);
  assign s3_bg   = palette_color(s3_attr_q[7:4]);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (!s3_visible_q) begin
        pix[k] = 16'h0000;
      end else begin
        pix[k] = s3_bits[7-k] ? s3_fg : s3_bg;
      end
    end
    // The rightmost pixel of the last column is always black.
    if (s3_last_q) begin
      pix[7] = 16'h0000;
    end
  end

  always_comb begin
    res_o.pixel_0     = pix[0];
    res_o.pixel_1     = pix[1];
    res_o.pixel_2     = pix[2];
    res_o.pixel_3     = pix[3];
    res_o.pixel_4     = pix[4];
    res_o.pixel_5     = pix[5];
    res_o.pixel_6     = pix[6];
    res_o.pixel_7     = pix[7];
    res_o.end_of_line = s3_last_q;
  end

  assign res_valid_o = s3_valid_q;
  assign inflight_o  = 2'(s1_render) + 2'(s2_render_q) + 2'(s3_valid_q);

endmodule

// File: rtl/core/tmcg_out_fifo.sv
// Result queue between the render pipeline and the output port.
// Depends on tmcg_pkg for the result type.
`timescale 1ns / 1ps

module tmcg_out_fifo #(
  parameter int Depth = tmcg_pkg::OUT_FIFO_DEPTH,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tmcg_pkg::out_res_t push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output tmcg_pkg::out_res_t data_o,
  output logic [CntW-1:0]    count_o
);
  import tmcg_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  out_res_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] rd_ptr_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (int'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (int'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
